@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the keyed value table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KVTD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KVTD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/kvtd_pkg.sv @@
// ----------------------------------------------------------------------------
// kvtd_pkg
// types and constants shared by the keyed value table cells and top level
// ----------------------------------------------------------------------------
package kvtd_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int KEY_W = 16;
	localparam int VAL_W = 32;
	localparam int DELTA_W = 31;
	localparam int IDX_W = 4;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_STORED    = 2'd0,
		ST_UNCHANGED = 2'd1,
		ST_FULL      = 2'd2,
		ST_CLEARED   = 2'd3
	} status_t;

	// request broadcast to every cell
	typedef struct packed {
		logic               vld;
		logic               clr;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [DELTA_W-1:0] delta;
	} kvtd_req_t;

	// per-cell status back to the top level
	typedef struct packed {
		logic occ;
		logic hit;
		logic sel;
		logic took;
	} kvtd_cell_st_t;

endpackage

@@ sv/kvtd_cell.sv @@
// ----------------------------------------------------------------------------
// kvtd_cell
// one table slot: key, value, occupancy and local deadband decision
// ----------------------------------------------------------------------------
module kvtd_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kvtd_pkg::kvtd_req_t                 req,
	input  logic                                any_hit,
	input  logic                                prev_occ,
	output kvtd_pkg::kvtd_cell_st_t             st,
	output logic [kvtd_pkg::VAL_W-1:0]          value
);
	import kvtd_pkg::*;

	logic              occ_q;
	logic              has_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic              sel_s2;
	logic              took_s2;

	logic              hit;
	logic              target;
	logic              upd;
	logic              wr_key;
	logic              selected;
	logic              take;
	logic [VAL_W:0]    diff;
	logic [VAL_W:0]    absdiff;

	always_comb begin
		hit      = occ_q && (key_q == req.key);
		target   = !occ_q && prev_occ;
		upd      = req.vld && !req.clr;
		wr_key   = upd && !any_hit && target;
		selected = upd && (hit || wr_key);
		diff     = {val_q[VAL_W-1], val_q} - {req.value[VAL_W-1], req.value};
		absdiff  = diff[VAL_W] ? (~diff + 1'b1) : diff;
		take     = !(hit && has_q) || (req.delta == '0) ||
			(absdiff >= {2'b00, req.delta});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			has_q   <= 1'b0;
			sel_s2  <= 1'b0;
			took_s2 <= 1'b0;
		end else begin
			sel_s2  <= selected;
			took_s2 <= selected && take;
			if (req.vld && req.clr) begin
				occ_q <= 1'b0;
				has_q <= 1'b0;
			end else if (selected) begin
				occ_q <= 1'b1;
				if (take) begin
					has_q <= 1'b1;
				end else if (wr_key) begin
					has_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_q <= req.key;
		end
		if (selected && take) begin
			val_q <= req.value;
		end
	end

	assign st.occ  = occ_q;
	assign st.hit  = hit;
	assign st.sel  = sel_s2;
	assign st.took = took_s2;
	assign value   = val_q;

endmodule

@@ sv/keyed_value_table_deadband.sv @@
// ----------------------------------------------------------------------------
// keyed_value_table_deadband
// associative table of readings keyed by (sensor_id, value_kind) with
// deadband update, built as a row of slot cells
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on a rising edge with start high and busy low.
//   opcode update looks the key up in every slot at once, appends a slot
//   on a miss, and stores new_value unless the slot already holds a value
//   within min_delta of it. opcode clear empties the table.
//   each request gives one result: done is high for exactly one cycle with
//   status, entry_index and stored_value; the receiver cannot stall it.
//   the result follows the accepting edge through the slot lookup stage,
//   the one-hot result select stage and the result register. busy is high
//   from the accepting edge until done rises and is low while done is high,
//   so the next request can be taken at the edge that takes the result.
//   the occupancy chain runs from slot 0 upward: a slot is free for append
//   when it is empty and its lower neighbor is occupied.
//   reset empties the table and drops any request in flight; no sweep of
//   the slots is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_value_table_deadband #(
	parameter int TABLE_DEPTH = kvtd_pkg::DEF_TABLE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic [7:0]                         sensor_id,
	input  logic [7:0]                         value_kind,
	input  logic signed [31:0]                 new_value,
	input  logic [30:0]                        min_delta,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [3:0]                         entry_index,
	output logic signed [31:0]                 stored_value
);
	import kvtd_pkg::*;

	kvtd_req_t         req_s1;
	logic              v_s2;
	logic              clr_s2;
	logic              full_s2;
	logic              done_q;
	status_t           status_q;
	logic [IDX_W-1:0]  index_q;
	logic [VAL_W-1:0]  value_q;

	kvtd_cell_st_t     cst [TABLE_DEPTH];
	logic [VAL_W-1:0]  cval [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TABLE_DEPTH-1:0] occ_vec;
	logic [TABLE_DEPTH-1:0] sel_vec;
	logic [TABLE_DEPTH-1:0] took_vec;
	logic              any_hit;
	logic              accept;

	status_t           status_d;
	logic [IDX_W-1:0]  index_d;
	logic [VAL_W-1:0]  value_d;

	assign accept = start && !busy;
	assign busy   = req_s1.vld || v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1     <= '0;
			v_s2       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			req_s1.vld <= accept;
			if (accept) begin
				req_s1.clr   <= (opcode == OP_CLEAR);
				req_s1.key   <= {sensor_id, value_kind};
				req_s1.value <= new_value;
				req_s1.delta <= min_delta;
			end
			v_s2       <= req_s1.vld;
			done_q     <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		clr_s2  <= req_s1.clr;
		full_s2 <= !req_s1.clr && !any_hit && (&occ_vec);
		if (v_s2) begin
			status_q <= status_d;
			index_q  <= index_d;
			value_q  <= value_d;
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		kvtd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_s1),
			.any_hit  (any_hit),
			.prev_occ ((g == 0) ? 1'b1 : occ_vec[(g == 0) ? 0 : g-1]),
			.st       (cst[g]),
			.value    (cval[g])
		);
		assign hit_vec[g]  = cst[g].hit;
		assign occ_vec[g]  = cst[g].occ;
		assign sel_vec[g]  = cst[g].sel;
		assign took_vec[g] = cst[g].took;
	end

	assign any_hit = |hit_vec;

	always_comb begin
		index_d = '0;
		value_d = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (sel_vec[i]) begin
				index_d = index_d | IDX_W'(i);
				value_d = value_d | cval[i];
			end
		end
		if (clr_s2) begin
			status_d = ST_CLEARED;
		end else if (full_s2) begin
			status_d = ST_FULL;
		end else if (|took_vec) begin
			status_d = ST_STORED;
		end else begin
			status_d = ST_UNCHANGED;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign entry_index  = index_q;
	assign stored_value = value_q;

	`KVTD_ASSERT_NXT(a_busy_after_req, accept, busy, "busy low after a request")
	`KVTD_ASSERT_NOW(a_sel_onehot, v_s2, $onehot0(sel_vec), "several slots selected")
	`KVTD_ASSERT_NOW(a_sel_vs_status, v_s2 && (clr_s2 || full_s2), sel_vec == '0,
		"slot selected on clear or full")
	`KVTD_ASSERT_NOW(a_done_timing, done, $past(v_s2) && !busy, "result without request")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for keyed_value_table_deadband: directed tests fill
// the table to full, probe the deadband edges and clear; then random traffic
// over a small key pool. each result is checked against a local table model.
// ----------------------------------------------------------------------------
module tb_top;
	import kvtd_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		status_t            status;
		logic [IDX_W-1:0]   index;
		logic signed [31:0] value;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic opcode = 1'b0;
	logic [7:0] sensor_id = '0;
	logic [7:0] value_kind = '0;
	logic signed [31:0] new_value = '0;
	logic [30:0] min_delta = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic [3:0] entry_index;
	logic signed [31:0] stored_value;

	logic [KEY_W-1:0] slot_key [DEPTH];
	logic signed [31:0] slot_val [DEPTH];
	bit slot_filled [DEPTH];
	int unsigned slot_count = 0;

	table_result_t pending_results[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	keyed_value_table_deadband uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.sensor_id(sensor_id),
		.value_kind(value_kind),
		.new_value(new_value),
		.min_delta(min_delta),
		.done(done),
		.status(status),
		.entry_index(entry_index),
		.stored_value(stored_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic table_result_t predict_reading(input opcode_t op,
			input logic [KEY_W-1:0] key, input logic signed [31:0] val,
			input logic [30:0] delta);
		table_result_t r;
		int slot;
		bit found;
		bit take;
		logic [32:0] diff;
		logic [32:0] mag;
		r.status = ST_CLEARED;
		r.index = '0;
		r.value = '0;
		if (op == OP_CLEAR) begin
			slot_count = 0;
			foreach (slot_filled[i])
				slot_filled[i] = 1'b0;
			return r;
		end
		found = 1'b0;
		slot = 0;
		for (int i = 0; i < slot_count; i++)
			if (!found && slot_key[i] == key) begin
				slot = i;
				found = 1'b1;
			end
		if (!found) begin
			if (slot_count == DEPTH) begin
				r.status = ST_FULL;
				return r;
			end
			slot = slot_count;
			slot_key[slot] = key;
			slot_filled[slot] = 1'b0;
			slot_count++;
		end
		take = !slot_filled[slot] || delta == '0;
		if (!take) begin
			// 33-bit difference, no overflow
			diff = {slot_val[slot][31], slot_val[slot]} - {val[31], val};
			mag = diff[32] ? -diff : diff;
			take = mag >= {2'b00, delta};
		end
		if (take) begin
			slot_val[slot] = val;
			slot_filled[slot] = 1'b1;
			r.status = ST_STORED;
		end else begin
			r.status = ST_UNCHANGED;
		end
		r.index = IDX_W'(slot);
		r.value = slot_val[slot];
		return r;
	endfunction

	function automatic bit lookup_reading(input logic [KEY_W-1:0] key,
			output logic signed [31:0] held);
		held = '0;
		for (int i = 0; i < slot_count; i++)
			if (slot_key[i] == key && slot_filled[i]) begin
				held = slot_val[i];
				return 1'b1;
			end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d index %0d",
					status, entry_index));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				if (entry_index !== want.index)
					report_mismatch($sformatf("entry_index %0d, expected %0d",
						entry_index, want.index));
				if (stored_value !== want.value)
					report_mismatch($sformatf("stored_value %0d, expected %0d",
						stored_value, want.value));
			end
		end
	end

	task automatic send_req(input opcode_t op, input logic [7:0] id,
			input logic [7:0] kind, input logic signed [31:0] val,
			input logic [30:0] delta);
		start <= 1'b1;
		opcode <= op;
		sensor_id <= id;
		value_kind <= kind;
		new_value <= val;
		min_delta <= delta;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_results.push_back(predict_reading(op, {id, kind}, val, delta));
	endtask

	task automatic idle_gap(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_clear_on_empty();
		send_req(OP_CLEAR, 8'hff, 8'h00, 32'sh7fff_ffff, 31'h7fff_ffff);
		wait_drain();
	endtask

	task automatic test_fill_to_full();
		// slot 0 fresh with the widest deadband still stores
		send_req(OP_UPDATE, 8'h00, 8'hff, 32'sh8000_0000, 31'h7fff_ffff);
		for (int i = 1; i < DEPTH; i++)
			send_req(OP_UPDATE, 8'(i * 17), 8'(255 - i * 17), $urandom, 31'($urandom));
		send_req(OP_UPDATE, 8'h5a, 8'ha5, 32'sh1234_5678, '0);
		send_req(OP_UPDATE, 8'hff, 8'h00, 32'sh0000_0001, '0);
		wait_drain();
	endtask

	task automatic test_deadband_edges();
		send_req(OP_UPDATE, 8'h00, 8'hff, 32'sh7fff_ffff, 31'h7fff_ffff);
		send_req(OP_UPDATE, 8'h00, 8'hff, 32'sh7fff_fffa, 31'd6);
		send_req(OP_UPDATE, 8'h00, 8'hff, 32'sh7fff_fff9, 31'd6);
		send_req(OP_UPDATE, 8'h00, 8'hff, 32'sh7fff_fff9, '0);
		send_req(OP_CLEAR, 8'h00, 8'h00, '0, '0);
		send_req(OP_UPDATE, 8'h00, 8'hff, 32'sh7fff_fff9, 31'h7fff_ffff);
		wait_drain();
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		logic [KEY_W-1:0] key_pool [24];
		int unsigned sent;
		int unsigned burst_len;
		int unsigned mode;
		int offset;
		opcode_t op;
		logic [KEY_W-1:0] key;
		logic signed [31:0] val;
		logic signed [31:0] held;
		logic [30:0] delta;
		bit has_held;
		for (int i = 0; i < 24; i++)
			key_pool[i] = KEY_W'($urandom);
		sent = 0;
		while (sent < n_items) begin
			burst_len = $urandom_range(1, 12);
			repeat (burst_len) begin
				op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_UPDATE;
				key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom)
					: key_pool[$urandom_range(0, 23)];
				has_held = lookup_reading(key, held);
				mode = $urandom_range(0, 9);
				val = $urandom;
				delta = 31'($urandom);
				if (has_held && mode >= 3) begin
					// near the held reading so the deadband decides
					offset = int'($urandom_range(0, 128)) - 64;
					val = held + offset;
					case (mode)
						3, 4, 5: delta = 31'($urandom_range(0, 100));
						6: delta = '0;
						7: delta = 31'(offset < 0 ? -offset : offset);
						default: delta = 31'($urandom_range(1, 64));
					endcase
				end
				send_req(op, key[15:8], key[7:0], val, delta);
				sent++;
			end
			if ($urandom_range(0, 15) == 0)
				wait_drain();
			else if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 8));
		end
		wait_drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clear_on_empty();
		test_fill_to_full();
		test_deadband_edges();
		test_random_traffic(950);
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", error_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ keyed_value_table_deadband.f @@
+incdir+sv
sv/kvtd_pkg.sv
sv/kvtd_cell.sv
sv/keyed_value_table_deadband.sv
sim/tb_top.sv
